/* hw/rtl/mphp_pkg.sv */
// ----------------------------------------------------------------------------
// MQTT header parser package
// Shared types, codes and helper functions for the MQTT header parser.
// ----------------------------------------------------------------------------
package mphp_pkg;

   localparam int MAX_LENGTH_BYTES = 4;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [4:0] PH_HEADER    = 5'd0;
   localparam logic [4:0] PH_REMLEN    = 5'd1;
   localparam logic [4:0] PH_PROTONAME = 5'd2;
   localparam logic [4:0] PH_VERSION   = 5'd3;
   localparam logic [4:0] PH_FLAGS     = 5'd4;
   localparam logic [4:0] PH_KEEPALIVE = 5'd5;
   localparam logic [4:0] PH_CLIENTID  = 5'd6;
   localparam logic [4:0] PH_WILLTOPIC = 5'd7;
   localparam logic [4:0] PH_WILLMSG   = 5'd8;
   localparam logic [4:0] PH_USER      = 5'd9;
   localparam logic [4:0] PH_PASS      = 5'd10;
   localparam logic [4:0] PH_CONNACK   = 5'd11;
   localparam logic [4:0] PH_TOPIC     = 5'd12;
   localparam logic [4:0] PH_MSGID     = 5'd13;

   localparam logic [3:0] TAG_HEADER = 4'd0;
   localparam logic [3:0] TAG_REMLEN = 4'd1;
   localparam logic [3:0] TAG_ERROR  = 4'd14;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_REMLEN = 2'd1;
   localparam logic [1:0] ERR_TYPE   = 2'd2;

   localparam logic [3:0] PT_CONNECT = 4'd1;
   localparam logic [3:0] PT_CONNACK = 4'd2;
   localparam logic [3:0] PT_PUBLISH = 4'd3;
   localparam logic [3:0] PT_PUBACK  = 4'd4;
   localparam logic [3:0] PT_PUBREC  = 4'd5;
   localparam logic [3:0] PT_PUBREL  = 4'd6;
   localparam logic [3:0] PT_PUBCOMP = 4'd7;

   typedef struct packed {
      logic [3:0]  tag;
      logic [27:0] value;
      logic        is_length;
      logic        last_in_field;
      logic        packet_done;
      logic [1:0]  error_code;
   } result_type;

   // Field that follows phase p; PH_HEADER once the packet's header is done.
   function automatic logic [4:0] successor(input logic [4:0] p, input logic [7:0] flags);
      logic [4:0] n;
      n = PH_HEADER;
      case (p)
         PH_PROTONAME: n = PH_VERSION;
         PH_VERSION:   n = PH_FLAGS;
         PH_FLAGS:     n = PH_KEEPALIVE;
         PH_KEEPALIVE: n = PH_CLIENTID;
         PH_CLIENTID: begin
            if (flags[2])      n = PH_WILLTOPIC;
            else if (flags[7]) n = PH_USER;
            else if (flags[6]) n = PH_PASS;
         end
         PH_WILLTOPIC: n = PH_WILLMSG;
         PH_WILLMSG: begin
            if (flags[7])      n = PH_USER;
            else if (flags[6]) n = PH_PASS;
         end
         PH_USER: begin
            if (flags[6]) n = PH_PASS;
         end
         PH_TOPIC: n = PH_MSGID;
         default:  n = PH_HEADER;
      endcase
      return n;
   endfunction

endpackage

/* hw/rtl/mphp_if.sv */
// ----------------------------------------------------------------------------
// MQTT header parser channels
// Valid/ready channel interfaces for requests, results and the CSR write.
// ----------------------------------------------------------------------------
interface mphp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mphp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  tag;
   logic [27:0] value;
   logic        is_length;
   logic        last_in_field;
   logic        packet_done;
   logic [1:0]  error_code;
   modport source (output valid, output tag, output value, output is_length,
                   output last_in_field, output packet_done, output error_code,
                   input ready);
   modport sink   (input valid, input tag, input value, input is_length,
                   input last_in_field, input packet_done, input error_code,
                   output ready);
endinterface

interface mphp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/mphp_front.sv */
// ----------------------------------------------------------------------------
// MQTT header parser front end
// Walks the byte stream one byte per cycle while byte_fire is high and forms the result items.
// ----------------------------------------------------------------------------
module mphp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_fire,
   input  logic [7:0]           data_byte,
   input  logic                 limit_we,
   input  logic [15:0]          limit_data,
   output logic                 push,
   output mphp_pkg::result_type push_item
);

   logic [15:0] limit_ff, limit_in;
   logic [4:0]  phase_ff, phase_in;
   logic [3:0]  ptype_ff, ptype_in;
   logic [7:0]  flags_ff, flags_in;
   logic [27:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] slen_ff, slen_in;
   logic [7:0]  high_ff, high_in;

   logic [4:0]  next_ph;
   logic [27:0] shifted;
   logic [15:0] word;
   logic [15:0] shown;
   logic [16:0] pos_inc;
   logic        lastf;

   always_comb begin
      limit_in  = limit_we ? limit_data : limit_ff;
      phase_in  = phase_ff;
      ptype_in  = ptype_ff;
      flags_in  = flags_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      slen_in   = slen_ff;
      high_in   = high_ff;
      push      = 1'b0;
      push_item = '0;
      next_ph   = mphp_pkg::successor(phase_ff, flags_ff);
      word      = {high_ff, data_byte};
      shown     = (slen_ff < limit_ff) ? slen_ff : limit_ff;
      pos_inc   = {1'b0, pos_ff} + 17'd1;
      lastf     = 1'b0;
      case (cnt_ff[1:0])
         2'd0:    shifted = {21'd0, data_byte[6:0]};
         2'd1:    shifted = {14'd0, data_byte[6:0], 7'd0};
         2'd2:    shifted = {7'd0, data_byte[6:0], 14'd0};
         default: shifted = {data_byte[6:0], 21'd0};
      endcase

      if (byte_fire) begin
         case (phase_ff)
            mphp_pkg::PH_REMLEN: begin
               acc_in = acc_ff | shifted;
               cnt_in = cnt_ff + 3'd1;
               if (data_byte[7]) begin
                  if (cnt_in == 3'(mphp_pkg::MAX_LENGTH_BYTES)) begin
                     phase_in = mphp_pkg::PH_HEADER;
                     cnt_in   = '0;
                     pos_in   = '0;
                     push     = 1'b1;
                     push_item.tag           = mphp_pkg::TAG_ERROR;
                     push_item.last_in_field = 1'b1;
                     push_item.error_code    = mphp_pkg::ERR_REMLEN;
                  end
               end else begin
                  cnt_in = '0;
                  pos_in = '0;
                  push   = 1'b1;
                  push_item.last_in_field = 1'b1;
                  case (ptype_ff)
                     mphp_pkg::PT_CONNECT: phase_in = mphp_pkg::PH_PROTONAME;
                     mphp_pkg::PT_CONNACK: phase_in = mphp_pkg::PH_CONNACK;
                     mphp_pkg::PT_PUBLISH: phase_in = mphp_pkg::PH_TOPIC;
                     mphp_pkg::PT_PUBACK, mphp_pkg::PT_PUBREC,
                     mphp_pkg::PT_PUBREL, mphp_pkg::PT_PUBCOMP:
                        phase_in = mphp_pkg::PH_MSGID;
                     default: phase_in = mphp_pkg::PH_HEADER;
                  endcase
                  if (phase_in == mphp_pkg::PH_HEADER) begin
                     push_item.tag        = mphp_pkg::TAG_ERROR;
                     push_item.value      = {24'd0, ptype_ff};
                     push_item.error_code = mphp_pkg::ERR_TYPE;
                  end else begin
                     push_item.tag   = mphp_pkg::TAG_REMLEN;
                     push_item.value = acc_in;
                  end
               end
            end
            mphp_pkg::PH_VERSION, mphp_pkg::PH_FLAGS: begin
               if (phase_ff == mphp_pkg::PH_FLAGS) begin
                  flags_in = data_byte;
               end
               next_ph  = mphp_pkg::successor(phase_ff, flags_in);
               phase_in = next_ph;
               cnt_in   = '0;
               pos_in   = '0;
               push     = 1'b1;
               push_item.tag           = phase_ff[3:0];
               push_item.value         = {20'd0, data_byte};
               push_item.last_in_field = 1'b1;
               push_item.packet_done   = (next_ph == mphp_pkg::PH_HEADER);
            end
            mphp_pkg::PH_KEEPALIVE, mphp_pkg::PH_CONNACK, mphp_pkg::PH_MSGID: begin
               if (cnt_ff == 3'd0) begin
                  high_in = data_byte;
                  cnt_in  = 3'd1;
               end else begin
                  phase_in = next_ph;
                  cnt_in   = '0;
                  pos_in   = '0;
                  push     = 1'b1;
                  push_item.tag           = phase_ff[3:0];
                  push_item.value         = {12'd0, word};
                  push_item.last_in_field = 1'b1;
                  push_item.packet_done   = (next_ph == mphp_pkg::PH_HEADER);
               end
            end
            mphp_pkg::PH_PROTONAME, mphp_pkg::PH_CLIENTID, mphp_pkg::PH_WILLTOPIC,
            mphp_pkg::PH_WILLMSG, mphp_pkg::PH_USER, mphp_pkg::PH_PASS,
            mphp_pkg::PH_TOPIC: begin
               if (cnt_ff == 3'd0) begin
                  high_in = data_byte;
                  cnt_in  = 3'd1;
               end else if (cnt_ff == 3'd1) begin
                  slen_in = word;
                  pos_in  = '0;
                  lastf   = (word == 16'd0) || (limit_ff == 16'd0);
                  if (word == 16'd0) begin
                     phase_in = next_ph;
                     cnt_in   = '0;
                  end else begin
                     cnt_in = 3'd2;
                  end
                  push = 1'b1;
                  push_item.tag           = phase_ff[3:0];
                  push_item.value         = {12'd0, word};
                  push_item.is_length     = 1'b1;
                  push_item.last_in_field = lastf;
                  push_item.packet_done   = lastf && (next_ph == mphp_pkg::PH_HEADER);
               end else begin
                  pos_in = pos_inc[15:0];
                  // Bytes beyond the limit are swallowed without a result.
                  if (pos_in >= slen_ff) begin
                     phase_in = next_ph;
                     cnt_in   = '0;
                     pos_in   = '0;
                  end
                  if (pos_ff < shown) begin
                     lastf = (pos_inc == {1'b0, shown});
                     push  = 1'b1;
                     push_item.tag           = phase_ff[3:0];
                     push_item.value         = {20'd0, data_byte};
                     push_item.last_in_field = lastf;
                     push_item.packet_done   = lastf && (next_ph == mphp_pkg::PH_HEADER);
                  end
               end
            end
            default: begin
               ptype_in = data_byte[7:4];
               flags_in = '0;
               acc_in   = '0;
               phase_in = mphp_pkg::PH_REMLEN;
               cnt_in   = '0;
               pos_in   = '0;
               push     = 1'b1;
               push_item.tag           = mphp_pkg::TAG_HEADER;
               push_item.value         = {20'd0, data_byte};
               push_item.last_in_field = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'hffff;
         phase_ff <= mphp_pkg::PH_HEADER;
         ptype_ff <= '0;
         flags_ff <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         pos_ff   <= '0;
         slen_ff  <= '0;
         high_ff  <= '0;
      end else begin
         limit_ff <= limit_in;
         phase_ff <= phase_in;
         ptype_ff <= ptype_in;
         flags_ff <= flags_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         slen_ff  <= slen_in;
         high_ff  <= high_in;
      end
   end

`ifndef SYNTHESIS
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      push && push_item.tag == mphp_pkg::TAG_ERROR |-> push_item.last_in_field)
      else $error("error result without last_in_field");
   a_error_resync: assert property (@(posedge clock) disable iff (reset)
      push && push_item.tag == mphp_pkg::TAG_ERROR |=> phase_ff == mphp_pkg::PH_HEADER)
      else $error("parser did not return to header wait after an error");
   a_header_then_remlen: assert property (@(posedge clock) disable iff (reset)
      push && push_item.tag == mphp_pkg::TAG_HEADER |=> phase_ff == mphp_pkg::PH_REMLEN)
      else $error("header byte not followed by remaining length phase");
`endif

endmodule

/* hw/rtl/mphp_queue.sv */
// ----------------------------------------------------------------------------
// MQTT header parser result queue
// Two-entry queue between the parser and the result channel.
// ----------------------------------------------------------------------------
module mphp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mphp_pkg::result_type push_item,
   output logic                 has_room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mphp_pkg::result_type out_item
);

   mphp_pkg::result_type mem_ff [mphp_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign has_room  = (count_ff != 2'(mphp_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> has_room)
      else $error("push into a full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(mphp_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow a push");
`endif

endmodule

/* hw/rtl/mqtt_packet_header_parser.sv */
// ----------------------------------------------------------------------------
// MQTT packet header parser
// Parses MQTT fixed and variable headers from a byte stream.
// ----------------------------------------------------------------------------
// Each request carries one stream byte and gives zero or one result. The
// parser takes one request every clock cycle while the queue has room; its
// state update is combinational logic. Results pass through a two-entry
// queue, so a request is still taken while a result waits, and requests
// stall only when the result side has held off long enough to fill that
// queue. The CSR write sets the string length limit and is always ready.
module mqtt_packet_header_parser (
   input logic          clock,
   input logic          reset,
   mphp_req_if.sink     req_ch,
   mphp_rsp_if.source   rsp_ch,
   mphp_csr_if.sink     csr_ch
);

   logic                 byte_fire;
   logic                 push;
   logic                 has_room;
   mphp_pkg::result_type push_item;
   mphp_pkg::result_type out_item;

   assign req_ch.ready = has_room;
   assign byte_fire    = req_ch.valid && has_room;
   assign csr_ch.ready = 1'b1;

   mphp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_fire  (byte_fire),
      .data_byte  (req_ch.data_byte),
      .limit_we   (csr_ch.valid),
      .limit_data (csr_ch.data),
      .push       (push),
      .push_item  (push_item)
   );

   mphp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .has_room  (has_room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   assign rsp_ch.tag           = out_item.tag;
   assign rsp_ch.value         = out_item.value;
   assign rsp_ch.is_length     = out_item.is_length;
   assign rsp_ch.last_in_field = out_item.last_in_field;
   assign rsp_ch.packet_done   = out_item.packet_done;
   assign rsp_ch.error_code    = out_item.error_code;

endmodule
